// File: design/tsc_pkg.sv
// Package for the time-sync command parser: types, codes and constants.
// No dependencies; used by every module of the block but the RAM, by scoped names.
`default_nettype none

package tsc_pkg;

  // Line store size (one entry is kept spare, as the usable fill is one less)
  localparam int unsigned LINE_BYTES  = 32;
  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [2:0] KIND_CONSUMED = 3'd0;
  localparam logic [2:0] KIND_PASSED   = 3'd1;
  localparam logic [2:0] KIND_UNIX     = 3'd2;
  localparam logic [2:0] KIND_DATETIME = 3'd3;
  localparam logic [2:0] KIND_INVALID  = 3'd4;

  // Request codes travelling from front to back
  typedef enum logic [1:0] {
    OP_CONSUMED = 2'd0,
    OP_PASSED   = 2'd1,
    OP_PARSE    = 2'd2
  } cmd_op_e;

  localparam logic [31:0] UNIX_THRESHOLD = 32'd1000000000;

  // Characters
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Date-time pattern: positions 0 to DT_LAST after the leading fill
  localparam logic [4:0] DT_LAST = 5'd18;
  localparam logic [4:0] DT_DONE = 5'd19;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_fill(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_EQ);
  endfunction

endpackage

`default_nettype wire

// File: design/tsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/tsc_fifo.sv
// Short register queue carrying requests from the front to the back.
// Depends on tsc_pkg for its depth.
`default_nettype none

module tsc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned Depth = tsc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] data_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/tsc_front.sv
// Front end: accepts serial bytes, tracks the open command, fills the line
// store and queues one request per byte. Depends on tsc_pkg.
`default_nettype none

module tsc_front #(
  parameter int unsigned LINE_BYTES = tsc_pkg::LINE_BYTES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               full_o,
  output logic                               req_push_o,
  output tsc_pkg::cmd_op_e                   req_op_o,
  output logic      [$clog2(LINE_BYTES)-1:0] req_fill_o,
  input  wire logic                          req_full_i,
  input  wire logic                          parse_done_i,
  output logic                               ram_we_o,
  output logic      [$clog2(LINE_BYTES)-1:0] ram_waddr_o,
  output logic      [7:0]                    ram_wdata_o
);

  localparam int unsigned FillW = $clog2(LINE_BYTES);

  logic             active_q, active_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             pending_q, pending_d;
  logic             accept;
  logic             line_end;

  // the line store may not change while a parse still reads it
  assign full_o   = req_full_i || (pending_q && active_q);
  assign accept   = push_i && !full_o;
  assign line_end = (rx_byte_i == tsc_pkg::CH_CR) || (rx_byte_i == tsc_pkg::CH_LF);

  assign req_push_o  = accept;
  assign req_fill_o  = fill_q;
  assign ram_waddr_o = fill_q;
  assign ram_wdata_o = rx_byte_i;

  always_comb begin
    active_d  = active_q;
    fill_d    = fill_q;
    pending_d = pending_q && !parse_done_i;
    req_op_o  = tsc_pkg::OP_CONSUMED;
    ram_we_o  = 1'b0;
    if (accept) begin
      if (!active_q) begin
        if (rx_byte_i == tsc_pkg::CH_T) begin
          active_d = 1'b1;
          fill_d   = '0;
        end else begin
          req_op_o = tsc_pkg::OP_PASSED;
        end
      end else if (line_end) begin
        req_op_o  = tsc_pkg::OP_PARSE;
        active_d  = 1'b0;
        fill_d    = '0;
        pending_d = 1'b1;
      end else if (fill_q < FillW'(LINE_BYTES - 1)) begin
        ram_we_o = 1'b1;
        fill_d   = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      fill_q    <= '0;
      pending_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      fill_q    <= fill_d;
      pending_q <= pending_d;
    end
  end

`ifndef SYNTHESIS
  a_no_write_during_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !pending_q)
    else $error("line store written while a parse is pending");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(LINE_BYTES - 1))
    else $error("fill count beyond usable line length");
`endif

endmodule

`default_nettype wire

// File: design/tsc_back.sv
// Back end: takes queued requests, walks the line store for a parse (Unix
// seconds and date-time in one pass) and holds the result. Depends on tsc_pkg.
`default_nettype none

module tsc_back #(
  parameter int unsigned LINE_BYTES = tsc_pkg::LINE_BYTES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_empty_i,
  input  wire tsc_pkg::cmd_op_e              req_op_i,
  input  wire logic [$clog2(LINE_BYTES)-1:0] req_fill_i,
  output logic                               req_pop_o,
  output logic                               parse_done_o,
  output logic      [$clog2(LINE_BYTES)-1:0] ram_raddr_o,
  input  wire logic [7:0]                    ram_rdata_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic      [2:0]                    kind_o,
  output logic      [31:0]                   epoch_secs_o,
  output logic      [13:0]                   year_o,
  output logic      [3:0]                    month_o,
  output logic      [4:0]                    day_o,
  output logic      [4:0]                    hour_o,
  output logic      [5:0]                    minute_o,
  output logic      [5:0]                    second_o
);

  localparam int unsigned FillW = $clog2(LINE_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    U_START,
    U_SKIP,
    U_DIGITS,
    U_DONE
  } unix_phase_e;

  state_e           state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] pos_q, pos_d;
  logic             eval_vld_q, eval_vld_d;
  logic             eval_end_q, eval_end_d;

  unix_phase_e      u_phase_q, u_phase_d;
  logic [31:0]      u_val_q, u_val_d;
  logic             u_any_q, u_any_d;

  logic             dt_skip_q, dt_skip_d;
  logic             dt_fail_q, dt_fail_d;
  logic [4:0]       dt_k_q, dt_k_d;
  logic [13:0]      dt_year_q, dt_year_d;
  logic [6:0]       dt_mon_q, dt_mon_d;
  logic [6:0]       dt_day_q, dt_day_d;
  logic [6:0]       dt_hour_q, dt_hour_d;
  logic [6:0]       dt_min_q, dt_min_d;
  logic [6:0]       dt_sec_q, dt_sec_d;

  logic             out_vld_q, out_vld_d;
  logic [2:0]       out_kind_q, out_kind_d;
  logic [31:0]      out_unix_q, out_unix_d;
  logic [13:0]      out_year_q, out_year_d;
  logic [3:0]       out_mon_q, out_mon_d;
  logic [4:0]       out_day_q, out_day_d;
  logic [4:0]       out_hour_q, out_hour_d;
  logic [5:0]       out_min_q, out_min_d;
  logic [5:0]       out_sec_q, out_sec_d;

  logic             out_free;
  logic [7:0]       c;
  logic             c_dec;
  logic [3:0]       c_dig;
  logic [4:0]       k;
  logic             unix_ok;
  logic             dt_ok;

  assign out_free    = !out_vld_q || pop_i;
  assign ram_raddr_o = pos_q;
  assign c           = eval_end_q ? 8'h00 : ram_rdata_i;
  assign c_dec       = tsc_pkg::is_dec(c);
  assign c_dig       = c[3:0];
  assign k           = dt_skip_q ? 5'd0 : dt_k_q;

  assign unix_ok = u_any_q && (u_val_q > tsc_pkg::UNIX_THRESHOLD);
  assign dt_ok   = !dt_fail_q && (dt_k_q == tsc_pkg::DT_DONE) &&
                   (dt_mon_q >= 7'd1) && (dt_mon_q <= 7'd12) &&
                   (dt_day_q >= 7'd1) && (dt_day_q <= 7'd31) &&
                   (dt_hour_q <= 7'd23) && (dt_min_q <= 7'd59) && (dt_sec_q <= 7'd59);

  assign empty_o      = !out_vld_q;
  assign kind_o       = out_kind_q;
  assign epoch_secs_o = out_unix_q;
  assign year_o       = out_year_q;
  assign month_o      = out_mon_q;
  assign day_o        = out_day_q;
  assign hour_o       = out_hour_q;
  assign minute_o     = out_min_q;
  assign second_o     = out_sec_q;

  // per-byte trackers for both parses
  always_comb begin
    u_phase_d = u_phase_q;
    u_val_d   = u_val_q;
    u_any_d   = u_any_q;
    dt_skip_d = dt_skip_q;
    dt_fail_d = dt_fail_q;
    dt_k_d    = dt_k_q;
    dt_year_d = dt_year_q;
    dt_mon_d  = dt_mon_q;
    dt_day_d  = dt_day_q;
    dt_hour_d = dt_hour_q;
    dt_min_d  = dt_min_q;
    dt_sec_d  = dt_sec_q;
    if (eval_vld_q) begin
      case (u_phase_q)
        U_START, U_SKIP: begin
          if (u_phase_q == U_START && (c == tsc_pkg::CH_U || c == tsc_pkg::CH_LC_U)) begin
            u_phase_d = U_SKIP;
          end else if (tsc_pkg::is_fill(c)) begin
            u_phase_d = U_SKIP;
          end else if (c_dec) begin
            u_phase_d = U_DIGITS;
            u_val_d   = {28'd0, c_dig};
            u_any_d   = 1'b1;
          end else begin
            u_phase_d = U_DONE;
          end
        end
        U_DIGITS: begin
          if (c_dec) begin
            u_val_d = 32'({u_val_q, 3'b000} + {u_val_q, 1'b0} + 35'(c_dig));
          end else begin
            u_phase_d = U_DONE;
          end
        end
        default: begin
          u_phase_d = U_DONE;
        end
      endcase

      if (!dt_fail_q && dt_k_q != tsc_pkg::DT_DONE &&
          !(dt_skip_q && tsc_pkg::is_fill(c))) begin
        dt_skip_d = 1'b0;
        dt_k_d    = k + 1'b1;
        case (k)
          5'd0, 5'd1, 5'd2, 5'd3: begin
            dt_fail_d = !c_dec;
            dt_year_d = 14'({dt_year_q, 3'b000} + {dt_year_q, 1'b0} + 17'(c_dig));
          end
          5'd4, 5'd7: begin
            dt_fail_d = (c != tsc_pkg::CH_DASH);
          end
          5'd5, 5'd6: begin
            dt_fail_d = !c_dec;
            dt_mon_d  = 7'({dt_mon_q, 3'b000} + {dt_mon_q, 1'b0} + 10'(c_dig));
          end
          5'd8, 5'd9: begin
            dt_fail_d = !c_dec;
            dt_day_d  = 7'({dt_day_q, 3'b000} + {dt_day_q, 1'b0} + 10'(c_dig));
          end
          5'd10: begin
            dt_fail_d = !(c == tsc_pkg::CH_SPACE || c == tsc_pkg::CH_T ||
                          c == tsc_pkg::CH_LC_T);
          end
          5'd11, 5'd12: begin
            dt_fail_d = !c_dec;
            dt_hour_d = 7'({dt_hour_q, 3'b000} + {dt_hour_q, 1'b0} + 10'(c_dig));
          end
          5'd13, 5'd16: begin
            dt_fail_d = (c != tsc_pkg::CH_COLON);
          end
          5'd14, 5'd15: begin
            dt_fail_d = !c_dec;
            dt_min_d  = 7'({dt_min_q, 3'b000} + {dt_min_q, 1'b0} + 10'(c_dig));
          end
          5'd17, tsc_pkg::DT_LAST: begin
            dt_fail_d = !c_dec;
            dt_sec_d  = 7'({dt_sec_q, 3'b000} + {dt_sec_q, 1'b0} + 10'(c_dig));
          end
          default: begin
            dt_fail_d = 1'b1;
          end
        endcase
      end
    end

    // fresh trackers for a new line
    if (state_q == S_IDLE) begin
      u_phase_d = U_START;
      u_val_d   = '0;
      u_any_d   = 1'b0;
      dt_skip_d = 1'b1;
      dt_fail_d = 1'b0;
      dt_k_d    = '0;
      dt_year_d = '0;
      dt_mon_d  = '0;
      dt_day_d  = '0;
      dt_hour_d = '0;
      dt_min_d  = '0;
      dt_sec_d  = '0;
    end
  end

  // sequencer and result register
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    pos_d        = pos_q;
    eval_vld_d   = 1'b0;
    eval_end_d   = 1'b0;
    req_pop_o    = 1'b0;
    parse_done_o = 1'b0;
    out_vld_d    = out_vld_q && !pop_i;
    out_kind_d   = out_kind_q;
    out_unix_d   = out_unix_q;
    out_year_d   = out_year_q;
    out_mon_d    = out_mon_q;
    out_day_d    = out_day_q;
    out_hour_d   = out_hour_q;
    out_min_d    = out_min_q;
    out_sec_d    = out_sec_q;
    case (state_q)
      S_IDLE: begin
        if (!req_empty_i) begin
          if (req_op_i == tsc_pkg::OP_PARSE) begin
            req_pop_o = 1'b1;
            fill_d    = req_fill_i;
            pos_d     = '0;
            state_d   = S_RUN;
          end else if (out_free) begin
            req_pop_o  = 1'b1;
            out_vld_d  = 1'b1;
            out_kind_d = (req_op_i == tsc_pkg::OP_PASSED) ? tsc_pkg::KIND_PASSED
                                                          : tsc_pkg::KIND_CONSUMED;
            out_unix_d = '0;
            out_year_d = '0;
            out_mon_d  = '0;
            out_day_d  = '0;
            out_hour_d = '0;
            out_min_d  = '0;
            out_sec_d  = '0;
          end
        end
      end
      S_RUN: begin
        eval_vld_d = 1'b1;
        eval_end_d = (pos_q == fill_q);
        if (pos_q == fill_q) begin
          state_d = S_DRAIN;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      S_DRAIN: begin
        parse_done_o = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_unix_d = '0;
          out_year_d = '0;
          out_mon_d  = '0;
          out_day_d  = '0;
          out_hour_d = '0;
          out_min_d  = '0;
          out_sec_d  = '0;
          if (unix_ok) begin
            out_kind_d = tsc_pkg::KIND_UNIX;
            out_unix_d = u_val_q;
          end else if (dt_ok) begin
            out_kind_d = tsc_pkg::KIND_DATETIME;
            out_year_d = dt_year_q;
            out_mon_d  = dt_mon_q[3:0];
            out_day_d  = dt_day_q[4:0];
            out_hour_d = dt_hour_q[4:0];
            out_min_d  = dt_min_q[5:0];
            out_sec_d  = dt_sec_q[5:0];
          end else begin
            out_kind_d = tsc_pkg::KIND_INVALID;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      pos_q      <= '0;
      eval_vld_q <= 1'b0;
      eval_end_q <= 1'b0;
      u_phase_q  <= U_START;
      u_val_q    <= '0;
      u_any_q    <= 1'b0;
      dt_skip_q  <= 1'b1;
      dt_fail_q  <= 1'b0;
      dt_k_q     <= '0;
      dt_year_q  <= '0;
      dt_mon_q   <= '0;
      dt_day_q   <= '0;
      dt_hour_q  <= '0;
      dt_min_q   <= '0;
      dt_sec_q   <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= tsc_pkg::KIND_CONSUMED;
      out_unix_q <= '0;
      out_year_q <= '0;
      out_mon_q  <= '0;
      out_day_q  <= '0;
      out_hour_q <= '0;
      out_min_q  <= '0;
      out_sec_q  <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      pos_q      <= pos_d;
      eval_vld_q <= eval_vld_d;
      eval_end_q <= eval_end_d;
      u_phase_q  <= u_phase_d;
      u_val_q    <= u_val_d;
      u_any_q    <= u_any_d;
      dt_skip_q  <= dt_skip_d;
      dt_fail_q  <= dt_fail_d;
      dt_k_q     <= dt_k_d;
      dt_year_q  <= dt_year_d;
      dt_mon_q   <= dt_mon_d;
      dt_day_q   <= dt_day_d;
      dt_hour_q  <= dt_hour_d;
      dt_min_q   <= dt_min_d;
      dt_sec_q   <= dt_sec_d;
      out_vld_q  <= out_vld_d;
      out_kind_q <= out_kind_d;
      out_unix_q <= out_unix_d;
      out_year_q <= out_year_d;
      out_mon_q  <= out_mon_d;
      out_day_q  <= out_day_d;
      out_hour_q <= out_hour_d;
      out_min_q  <= out_min_d;
      out_sec_q  <= out_sec_d;
    end
  end

`ifndef SYNTHESIS
  a_unix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q != tsc_pkg::KIND_UNIX) |-> (out_unix_q == '0))
    else $error("unix seconds set on a non-unix result");
  a_date_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q != tsc_pkg::KIND_DATETIME) |->
      (out_year_q == '0 && out_mon_q == '0 && out_day_q == '0 &&
       out_hour_q == '0 && out_min_q == '0 && out_sec_q == '0))
    else $error("date fields set on a non date-time result");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop_i) |=> out_vld_q)
    else $error("waiting result lost");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_done_o |=> (state_q == S_FINISH && !parse_done_o))
    else $error("parse done not followed by result stage");
`endif

endmodule

`default_nettype wire

// File: design/time_sync_command_parser_top.sv
// Top level of the time-sync command parser: front end, request queue,
// line store RAM and back end. Depends on tsc_pkg and all tsc_ modules.
//
// Usage: serial bytes enter on rx_byte_i through a queue-style port; a byte
// is taken at a clock edge with push high and full low. Every byte gives
// exactly one result, read from a queue-style port: the result is on the
// output fields while empty is low and is taken at an edge with pop high.
// Outside a command, 'T' opens one (consumed), other bytes pass through.
// Inside, bytes are stored (up to LINE_BYTES-1) and CR or LF closes the
// line, giving a Unix-seconds, date-time or invalid result.
// A consumed or passed byte passes the request queue and the output register.
// A line end is walked by the back end reading the line store one byte per
// cycle, then passes the drain and finish states. Throughput is one byte per
// cycle outside a parse while the queue has room; while a parse runs, bytes
// that would extend a newly opened line wait (full high) until the walk is
// over. A four-entry request queue and the output register let the input
// side go on while the receiver stalls; full rises once the queue fills.
// Reset clears command state, the queue and the output; the line store needs
// no clearing, as only positions written by the current command are used.
`default_nettype none

module time_sync_command_parser_top #(
  parameter int unsigned LINE_BYTES = tsc_pkg::LINE_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic      [2:0]  kind_o,
  output logic      [31:0] epoch_secs_o,
  output logic      [13:0] year_o,
  output logic      [3:0]  month_o,
  output logic      [4:0]  day_o,
  output logic      [4:0]  hour_o,
  output logic      [5:0]  minute_o,
  output logic      [5:0]  second_o
);

  localparam int unsigned FillW = $clog2(LINE_BYTES);
  localparam int unsigned ReqW  = FillW + 2;

  logic                 req_push, req_full, req_pop, req_empty;
  tsc_pkg::cmd_op_e     req_op_w, req_op_r;
  logic [FillW-1:0]     req_fill_w, req_fill_r;
  logic [ReqW-1:0]      req_rdata;
  logic                 parse_done;
  logic                 ram_we;
  logic [FillW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]           ram_wdata, ram_rdata;

  assign req_op_r   = tsc_pkg::cmd_op_e'(req_rdata[ReqW-1 -: 2]);
  assign req_fill_r = req_rdata[FillW-1:0];

  tsc_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .req_push_o  (req_push),
    .req_op_o    (req_op_w),
    .req_fill_o  (req_fill_w),
    .req_full_i  (req_full),
    .parse_done_i(parse_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  tsc_fifo #(
    .WIDTH(ReqW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (req_push),
    .wdata_i({req_op_w, req_fill_w}),
    .full_o (req_full),
    .pop_i  (req_pop),
    .rdata_o(req_rdata),
    .empty_o(req_empty)
  );

  tsc_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tsc_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_empty_i   (req_empty),
    .req_op_i      (req_op_r),
    .req_fill_i    (req_fill_r),
    .req_pop_o     (req_pop),
    .parse_done_o  (parse_done),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .empty_o       (empty),
    .pop_i         (pop),
    .kind_o        (kind_o),
    .epoch_secs_o  (epoch_secs_o),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o)
  );

endmodule

`default_nettype wire
